FILE: hdl/gpio_pkg.sv
// ----------------------------------------------------------------------------
// GPIO port package
// Shared constants, register indexes and types for the GPIO port with
// configuration lock.
// ----------------------------------------------------------------------------
package gpio_pkg;

    // Number of pins that are present on the port (8 to 16).
    localparam int PIN_COUNT = 16;

    // Pins at or above PIN_COUNT read as zero and ignore writes.
    localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);

    // Configuration reset value: every pin is a floating input.
    localparam logic [31:0] CFG_RESET = 32'h4444_4444;

    // Bit of the lock register that carries the key.
    localparam int KEY_POS = 16;

    typedef logic [2:0] reg_index_t;

    // Bus access codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register indexes.
    localparam reg_index_t REG_CFG_LOW  = 3'd0;
    localparam reg_index_t REG_CFG_HIGH = 3'd1;
    localparam reg_index_t REG_IN_DATA  = 3'd2;
    localparam reg_index_t REG_OUT_DATA = 3'd3;
    localparam reg_index_t REG_LOCK     = 3'd4;

endpackage

FILE: hdl/gpio_req_if.sv
// ----------------------------------------------------------------------------
// GPIO request channel
// One bus access word: opcode, register index, write data and pin levels.
// ----------------------------------------------------------------------------
interface gpio_req_if import gpio_pkg::*; ();

    logic        valid;
    logic        ready;
    logic        opcode;
    reg_index_t  reg_index;
    logic [31:0] write_data;
    logic [15:0] pin_levels;

    modport source (
        output valid,
        output opcode,
        output reg_index,
        output write_data,
        output pin_levels,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  reg_index,
        input  write_data,
        input  pin_levels,
        output ready
    );

endinterface

FILE: hdl/gpio_rsp_if.sv
// ----------------------------------------------------------------------------
// GPIO response channel
// One result word: read data, output levels and the lock status.
// ----------------------------------------------------------------------------
interface gpio_rsp_if import gpio_pkg::*; ();

    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] output_levels;
    logic        port_locked;

    modport source (
        output valid,
        output read_data,
        output output_levels,
        output port_locked,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_data,
        input  output_levels,
        input  port_locked,
        output ready
    );

endinterface

FILE: hdl/gpio_port_with_config_lock.sv
// ----------------------------------------------------------------------------
// GPIO port with configuration lock
// A port of up to sixteen pins behind five registers, with a key sequence
// that locks the configuration nibbles of selected pins until reset.
//
//   Channel  Direction  Contents
//   req      in         opcode, reg_index, write_data, pin_levels
//   rsp      out        read_data, output_levels, port_locked
//
// One word is accepted per cycle unless rsp stalls; each word passes through
// the input register and then the result register, which presents its response.
// The word is captured in an input register, all register updates happen as it
// moves on to the result register, and the response is held there.
// When rsp stalls, the input register keeps one more word and then req.ready
// drops until the result register is taken.
// Reset sets the valid flags and port state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module gpio_port_with_config_lock
    import gpio_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    gpio_req_if.sink        req,
    gpio_rsp_if.source      rsp
);

    // Progress through the key sequence.
    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_ONE   = 2'd1;
    localparam logic [1:0] STEP_ZERO  = 2'd2;
    localparam logic [1:0] STEP_ARMED = 2'd3;

    // Input register.
    logic        in_valid_reg;
    logic        in_opcode_reg;
    reg_index_t  in_index_reg;
    logic [31:0] in_data_reg;
    logic [15:0] in_pins_reg;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] out_read_reg;
    logic [15:0] out_levels_reg;
    logic        out_locked_reg;

    // Port state.
    logic [31:0] cfg_low_reg,   cfg_low_next;
    logic [31:0] cfg_high_reg,  cfg_high_next;
    logic [15:0] out_data_reg,  out_data_next;
    logic [15:0] lock_bits_reg, lock_bits_next;
    logic        lock_key_reg,  lock_key_next;
    logic [1:0]  lock_step_reg, lock_step_next;

    logic        advance;
    logic [31:0] read_next;
    logic [15:0] pin_locked;
    logic [31:0] low_mask;
    logic [31:0] high_mask;
    logic [15:0] wr_bits;
    logic        wr_key;
    logic        wr_same;

    // The word in the input register moves on when the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    assign pin_locked = lock_key_reg ? lock_bits_reg : 16'h0000;
    assign wr_bits    = in_data_reg[15:0] & PIN_MASK;
    assign wr_key     = in_data_reg[KEY_POS];
    assign wr_same    = (wr_bits == lock_bits_reg);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            low_mask[i*4 +: 4]  = (PIN_MASK[i] && !pin_locked[i]) ? 4'hF : 4'h0;
            high_mask[i*4 +: 4] = (PIN_MASK[i+8] && !pin_locked[i+8]) ? 4'hF : 4'h0;
        end
    end

    always_comb
    begin
        cfg_low_next   = cfg_low_reg;
        cfg_high_next  = cfg_high_reg;
        out_data_next  = out_data_reg;
        lock_bits_next = lock_bits_reg;
        lock_key_next  = lock_key_reg;
        lock_step_next = lock_step_reg;
        read_next      = 32'h0000_0000;

        if (in_opcode_reg == OP_WRITE)
        begin
            unique case (in_index_reg)
                REG_CFG_LOW:
                begin
                    cfg_low_next = (cfg_low_reg & ~low_mask) | (in_data_reg & low_mask);
                end
                REG_CFG_HIGH:
                begin
                    cfg_high_next = (cfg_high_reg & ~high_mask) | (in_data_reg & high_mask);
                end
                REG_OUT_DATA:
                begin
                    out_data_next = in_data_reg[15:0] & PIN_MASK;
                end
                REG_LOCK:
                begin
                    if (!lock_key_reg)
                    begin
                        priority if (lock_step_reg == STEP_ONE && !wr_key && wr_same)
                        begin
                            lock_step_next = STEP_ZERO;
                        end
                        else if (lock_step_reg == STEP_ZERO && wr_key && wr_same)
                        begin
                            lock_step_next = STEP_ARMED;
                        end
                        else
                        begin
                            // Any other write restarts the sequence.
                            lock_bits_next = wr_bits;
                            lock_step_next = wr_key ? STEP_ONE : STEP_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (in_index_reg)
                REG_CFG_LOW:  read_next = cfg_low_reg;
                REG_CFG_HIGH: read_next = cfg_high_reg;
                REG_IN_DATA:  read_next = {16'h0000, in_pins_reg & PIN_MASK};
                REG_OUT_DATA: read_next = {16'h0000, out_data_reg};
                REG_LOCK:
                begin
                    read_next = {15'h0000, lock_key_reg, lock_bits_reg};
                    // The read that follows a complete key sequence locks the port.
                    if (!lock_key_reg)
                    begin
                        lock_key_next  = (lock_step_reg == STEP_ARMED);
                        lock_step_next = STEP_IDLE;
                    end
                end
                default:      read_next = 32'h0000_0000;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_low_reg   <= CFG_RESET;
            cfg_high_reg  <= CFG_RESET;
            out_data_reg  <= 16'h0000;
            lock_bits_reg <= 16'h0000;
            lock_key_reg  <= 1'b0;
            lock_step_reg <= STEP_IDLE;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                cfg_low_reg   <= cfg_low_next;
                cfg_high_reg  <= cfg_high_next;
                out_data_reg  <= out_data_next;
                lock_bits_reg <= lock_bits_next;
                lock_key_reg  <= lock_key_next;
                lock_step_reg <= lock_step_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_opcode_reg <= req.opcode;
            in_index_reg  <= req.reg_index;
            in_data_reg   <= req.write_data;
            in_pins_reg   <= req.pin_levels;
        end
        if (advance)
        begin
            out_read_reg   <= read_next;
            out_levels_reg <= out_data_next;
            out_locked_reg <= lock_key_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_read_reg;
    assign rsp.output_levels = out_levels_reg;
    assign rsp.port_locked   = out_locked_reg;

    // Once locked, the port stays locked and its lock bits are frozen.
    assert property (@(posedge clk) disable iff (!rst_n)
        lock_key_reg |=> lock_key_reg && $stable(lock_bits_reg))
        else $error("lock state changed after the port was locked");

    // The key is set only by a lock read that follows a complete sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        !lock_key_reg ##1 lock_key_reg |->
            $past(advance && in_opcode_reg == OP_READ && in_index_reg == REG_LOCK
                  && lock_step_reg == STEP_ARMED))
        else $error("port locked without a complete key sequence");

    // A pending result is never overwritten while the response is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(out_read_reg))
        else $error("stalled result was lost or changed");

    // Low configuration nibbles of locked pins never change.
    assert property (@(posedge clk) disable iff (!rst_n)
        lock_key_reg |=> ((cfg_low_reg ^ $past(cfg_low_reg)) & ~low_mask) == 32'h0)
        else $error("locked low configuration nibble was written");

    // Absent pins never drive an output level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_data_reg & ~PIN_MASK) == 16'h0000)
        else $error("output data set on an absent pin");

endmodule
